>>> hw/rtl/qrr_pkg.sv
// qrr_pkg: shared widths, types and constants for the quartet rank pipeline
// no dependencies; imported by every module under hw/rtl
package qrr_pkg;

    localparam int ID_W   = 8;
    localparam int ID_MAX = 255;
    localparam int RANK_W = 28;
    localparam int NSTAGE = 5;

    // widths of the binomial terms for 8-bit ids
    localparam int C2_W = 15;
    localparam int C3_W = 22;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [1:0]        t_res;

    // resolution codes relative to ascending ids s1<s2<s3<s4
    localparam t_res RES_AB_CD = 2'd0;
    localparam t_res RES_AC_BD = 2'd1;
    localparam t_res RES_AD_BC = 2'd2;

    // multiplicative inverses of 3 for exact division of multiples of 3
    localparam logic [23:0] INV3_24 = 24'hAAAAAB;
    localparam logic [28:0] INV3_29 = 29'h0AAAAAAB;

    // per-stage load enables
    typedef logic [NSTAGE-1:0] t_stage_en;

endpackage

>>> hw/rtl/qrr_sort.sv
// qrr_sort: first pipeline stage, validity check, pair ordering and resolution
// depends on qrr_pkg
module qrr_sort (
    input  logic          i_clk,
    input  logic          i_en,
    input  qrr_pkg::t_id  i_first_a,
    input  qrr_pkg::t_id  i_first_b,
    input  qrr_pkg::t_id  i_second_c,
    input  qrr_pkg::t_id  i_second_d,
    output qrr_pkg::t_id  o_n1,
    output qrr_pkg::t_id  o_n2,
    output qrr_pkg::t_id  o_n3,
    output qrr_pkg::t_id  o_n4,
    output qrr_pkg::t_res o_res,
    output logic          o_bad
);
    import qrr_pkg::*;

    t_id  r_n1, r_n2, r_n3, r_n4;
    t_res r_res;
    logic r_bad;
    t_id  n_n1, n_n2, n_n3, n_n4;
    t_res n_res;
    logic n_bad;

    always_comb begin
        t_id lo1, hi1, lo2, hi2;
        t_id pa, pb, pc, pd;
        t_id s1, s2, s3, s4;
        logic zero_id, big_id, dup_id;

        zero_id = (i_first_a == '0) || (i_first_b == '0) ||
                  (i_second_c == '0) || (i_second_d == '0);
        big_id  = (32'(i_first_a) > ID_MAX) || (32'(i_first_b) > ID_MAX) ||
                  (32'(i_second_c) > ID_MAX) || (32'(i_second_d) > ID_MAX);
        dup_id  = (i_first_a == i_first_b) || (i_first_a == i_second_c) ||
                  (i_first_a == i_second_d) || (i_first_b == i_second_c) ||
                  (i_first_b == i_second_d) || (i_second_c == i_second_d);
        n_bad   = zero_id || big_id || dup_id;

        lo1 = (i_first_a > i_first_b) ? i_first_b : i_first_a;
        hi1 = (i_first_a > i_first_b) ? i_first_a : i_first_b;
        lo2 = (i_second_c > i_second_d) ? i_second_d : i_second_c;
        hi2 = (i_second_c > i_second_d) ? i_second_c : i_second_d;

        if (lo1 > lo2) begin
            pa = lo2; pb = hi2; pc = lo1; pd = hi1;
        end else begin
            pa = lo1; pb = hi1; pc = lo2; pd = hi2;
        end

        if (pb < pc) begin
            n_res = RES_AB_CD;
            s1 = pa; s2 = pb; s3 = pc; s4 = pd;
        end else if (pb < pd) begin
            n_res = RES_AC_BD;
            s1 = pa; s2 = pc; s3 = pb; s4 = pd;
        end else begin
            n_res = RES_AD_BC;
            s1 = pa; s2 = pc; s3 = pd; s4 = pb;
        end

        // a rejected quartet runs through with all-zero terms
        if (n_bad) begin
            n_res = RES_AB_CD;
            n_n1  = '0;
            n_n2  = '0;
            n_n3  = '0;
            n_n4  = '0;
        end else begin
            n_n1 = s1 - t_id'(1);
            n_n2 = s2 - t_id'(1);
            n_n3 = s3 - t_id'(1);
            n_n4 = s4 - t_id'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1  <= n_n1;
            r_n2  <= n_n2;
            r_n3  <= n_n3;
            r_n4  <= n_n4;
            r_res <= n_res;
            r_bad <= n_bad;
        end
    end

    assign o_n1  = r_n1;
    assign o_n2  = r_n2;
    assign o_n3  = r_n3;
    assign o_n4  = r_n4;
    assign o_res = r_res;
    assign o_bad = r_bad;

endmodule

>>> hw/rtl/qrr_binom.sv
// qrr_binom: three pipeline stages computing C(n1,1), C(n2,2), C(n3,3), C(n4,4)
// depends on qrr_pkg
module qrr_binom (
    input  logic                       i_clk,
    input  logic [2:0]                 i_en,
    input  qrr_pkg::t_id               i_n1,
    input  qrr_pkg::t_id               i_n2,
    input  qrr_pkg::t_id               i_n3,
    input  qrr_pkg::t_id               i_n4,
    output qrr_pkg::t_id               o_c1,
    output logic [qrr_pkg::C2_W-1:0]   o_c2,
    output logic [qrr_pkg::C3_W-1:0]   o_c3,
    output qrr_pkg::t_rank             o_c4
);
    import qrr_pkg::*;

    // stage a: pairwise products; a wrapped factor always meets a zero factor
    t_id          r_a_n1;
    logic [15:0]  r_a_p2, r_a_p3, r_a_p4a, r_a_p4b;
    t_id          r_a_n3m2;

    // stage b: full products
    t_id          r_b_n1;
    logic [C2_W-1:0] r_b_c2;
    logic [23:0]  r_b_p3;
    logic [31:0]  r_b_p4;

    // stage c: exact division by 6 and 24
    t_id          r_c_n1;
    logic [C2_W-1:0] r_c_c2;
    logic [C3_W-1:0] r_c_c3;
    t_rank        r_c_c4;

    logic [23:0]  n_c3_full;
    logic [28:0]  n_c4_full;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_n1   <= i_n1;
            r_a_p2   <= 16'(i_n2) * 16'(i_n2 - t_id'(1));
            r_a_p3   <= 16'(i_n3) * 16'(i_n3 - t_id'(1));
            r_a_n3m2 <= i_n3 - t_id'(2);
            r_a_p4a  <= 16'(i_n4) * 16'(i_n4 - t_id'(1));
            r_a_p4b  <= 16'(i_n4 - t_id'(2)) * 16'(i_n4 - t_id'(3));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_n1 <= r_a_n1;
            r_b_c2 <= r_a_p2[15:1];
            r_b_p3 <= 24'(r_a_p3) * 24'(r_a_n3m2);
            r_b_p4 <= 32'(r_a_p4a) * 32'(r_a_p4b);
        end
    end

    // product of consecutive integers is a multiple of 6 or 24, so the
    // quotient by 3 is a modular multiply by the inverse of 3
    always_comb begin
        n_c3_full = {1'b0, r_b_p3[23:1]} * INV3_24;
        n_c4_full = r_b_p4[31:3] * INV3_29;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_n1 <= r_b_n1;
            r_c_c2 <= r_b_c2;
            r_c_c3 <= n_c3_full[C3_W-1:0];
            r_c_c4 <= n_c4_full[RANK_W-1:0];
        end
    end

    assign o_c1 = r_c_n1;
    assign o_c2 = r_c_c2;
    assign o_c3 = r_c_c3;
    assign o_c4 = r_c_c4;

endmodule

>>> hw/rtl/quartet_rank_and_resolution.sv
// quartet_rank_and_resolution: top level, handshake control and final rank sum
// depends on qrr_pkg, qrr_sort, qrr_binom
//
// Takes one quartet split per request, pair {a,b} against pair {c,d}, with
// one-based 8-bit ids, and returns the resolution of the split relative to
// the ascending ids (0 ab|cd, 1 ac|bd, 2 ad|bc) together with the combinadic
// rank C(s1-1,1)+C(s2-1,2)+C(s3-1,3)+C(s4-1,4) of the sorted set. A zero id,
// an id above the maximum, or a repeated id sets invalid with rank and
// resolution zero. The pipeline is five register stages deep: ordering and
// checking, pairwise products, full products, exact division by 6 and 24,
// and the final sum. A new request is taken every cycle and one result leaves
// per cycle, as long as the output side is not stalled. Each stage holds its own
// valid bit and advances when it is empty or the stage after it moves, so a
// stall at the output fills empty stages before holding the input side.
module quartet_rank_and_resolution (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request side
    input  logic                 i_valid,
    output logic                 o_ready,
    input  qrr_pkg::t_id         i_first_a,
    input  qrr_pkg::t_id         i_first_b,
    input  qrr_pkg::t_id         i_second_c,
    input  qrr_pkg::t_id         i_second_d,
    // result side
    output logic                 o_valid,
    input  logic                 i_ready,
    output qrr_pkg::t_rank       o_subset_rank,
    output qrr_pkg::t_res        o_resolution,
    output logic                 o_invalid
);
    import qrr_pkg::*;

    // stage valid bits and per-stage advance
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    t_stage_en         w_en;

    // sort stage outputs
    t_id  w_n1, w_n2, w_n3, w_n4;
    t_res w_res;
    logic w_bad;

    // binomial terms
    t_id             w_c1;
    logic [C2_W-1:0] w_c2;
    logic [C3_W-1:0] w_c3;
    t_rank           w_c4;

    // resolution and invalid ride alongside the binomial stages
    t_res r_res_p [1:NSTAGE-1];
    logic r_bad_p [1:NSTAGE-1];

    t_rank r_rank;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    qrr_sort u_sort (
        .i_clk      (i_clk),
        .i_en       (w_en[0]),
        .i_first_a  (i_first_a),
        .i_first_b  (i_first_b),
        .i_second_c (i_second_c),
        .i_second_d (i_second_d),
        .o_n1       (w_n1),
        .o_n2       (w_n2),
        .o_n3       (w_n3),
        .o_n4       (w_n4),
        .o_res      (w_res),
        .o_bad      (w_bad)
    );

    qrr_binom u_binom (
        .i_clk (i_clk),
        .i_en  (w_en[3:1]),
        .i_n1  (w_n1),
        .i_n2  (w_n2),
        .i_n3  (w_n3),
        .i_n4  (w_n4),
        .o_c1  (w_c1),
        .o_c2  (w_c2),
        .o_c3  (w_c3),
        .o_c4  (w_c4)
    );

    // side-band delay line matching the binomial stages and the sum stage
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_res_p[1] <= w_res;
            r_bad_p[1] <= w_bad;
        end
        for (int k = 2; k < NSTAGE; k++) begin
            if (w_en[k]) begin
                r_res_p[k] <= r_res_p[k-1];
                r_bad_p[k] <= r_bad_p[k-1];
            end
        end
    end

    // final stage: sum of the four terms, all zero for a rejected quartet
    always_ff @(posedge i_clk) begin
        if (w_en[NSTAGE-1]) begin
            r_rank <= RANK_W'(w_c1) + RANK_W'(w_c2) + RANK_W'(w_c3) + w_c4;
        end
    end

    assign o_ready       = w_en[0];
    assign o_valid       = r_vld[NSTAGE-1];
    assign o_subset_rank = r_rank;
    assign o_resolution  = r_res_p[NSTAGE-1];
    assign o_invalid     = r_bad_p[NSTAGE-1];

endmodule

>>> tb/quartet_rank_and_resolution_tb.sv
// quartet_rank_and_resolution_tb: self-checking bench for the quartet rank pipeline
// depends on qrr_pkg and quartet_rank_and_resolution; drives requests, predicts results
// and compares them in order, with random idling on both handshakes
`timescale 1ns / 100ps

module quartet_rank_and_resolution_tb;

    import qrr_pkg::*;

    // one quartet split as it goes in
    typedef struct packed {
        t_id a;
        t_id b;
        t_id c;
        t_id d;
    } t_split;

    // one result as it comes out
    typedef struct packed {
        t_rank rank;
        t_res  res;
        logic  bad;
    } t_outcome;

    // a request plus, for table rows read off by hand, its known answer
    typedef struct {
        t_split   ids;
        bit       typed;
        t_outcome want;
    } t_request;

    localparam int N_RANDOM    = 1500;
    localparam int N_CALM_TAIL = 200;     // last requests go out with no idling
    localparam int STALL_LIMIT = 2000;    // cycles with no handshake at all
    localparam int MAX_REPORTS = 10;

    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_valid    = 1'b0;
    logic  o_ready;
    t_id   i_first_a  = '0;
    t_id   i_first_b  = '0;
    t_id   i_second_c = '0;
    t_id   i_second_d = '0;
    logic  o_valid;
    logic  i_ready    = 1'b0;
    t_rank o_subset_rank;
    t_res  o_resolution;
    logic  o_invalid;

    t_request directed_rows[$];
    t_request queued_splits[$];     // driven, not yet accepted
    t_outcome pending_results[$];   // accepted, result not yet seen
    int       mismatches  = 0;
    int       stall_count = 0;
    bit       calm_phase  = 1'b0;

    quartet_rank_and_resolution i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_first_a     (i_first_a),
        .i_first_b     (i_first_b),
        .i_second_c    (i_second_c),
        .i_second_d    (i_second_d),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_subset_rank (o_subset_rank),
        .o_resolution  (o_resolution),
        .o_invalid     (o_invalid)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // exact binomial, stepwise so every division is exact
    function automatic longint unsigned choose(longint unsigned n, int k);
        longint unsigned acc;
        acc = 1;
        if (n < k) return 0;
        for (int i = 0; i < k; i++) acc = acc * (n - i) / (i + 1);
        return acc;
    endfunction

    // expected result for one split
    function automatic t_outcome resolve_split(t_split q);
        int unsigned a, b, c, d, t;
        int unsigned s1, s2, s3, s4;
        t_outcome r;
        longint unsigned sum;
        a = q.a;
        b = q.b;
        c = q.c;
        d = q.d;
        r = '0;
        // zero id, id above the maximum, or any repeated id
        if (a == 0 || b == 0 || c == 0 || d == 0 ||
            a > ID_MAX || b > ID_MAX || c > ID_MAX || d > ID_MAX ||
            a == b || a == c || a == d || b == c || b == d || c == d) begin
            r.bad = 1'b1;
            return r;
        end
        // order each pair, then lead with the pair holding the smallest id
        if (c > d) begin t = c; c = d; d = t; end
        if (a > b) begin t = a; a = b; b = t; end
        if (a > c) begin
            t = a; a = c; c = t;
            t = b; b = d; d = t;
        end
        s1 = a;
        if (b < c) begin
            r.res = RES_AB_CD; s2 = b; s3 = c; s4 = d;
        end else if (b < d) begin
            r.res = RES_AC_BD; s2 = c; s3 = b; s4 = d;
        end else begin
            r.res = RES_AD_BC; s2 = c; s3 = d; s4 = b;
        end
        sum = choose(s1 - 1, 1) + choose(s2 - 1, 2) + choose(s3 - 1, 3) + choose(s4 - 1, 4);
        r.rank = t_rank'(sum);
        return r;
    endfunction

    task automatic add_row(input int a, input int b, input int c, input int d,
                           input bit typed, input int rank, input t_res res,
                           input bit bad);
        t_request rq;
        rq.ids   = '{a: t_id'(a), b: t_id'(b), c: t_id'(c), d: t_id'(d)};
        rq.typed = typed;
        rq.want  = '{rank: t_rank'(rank), res: res, bad: bad};
        directed_rows.insert(directed_rows.size(), rq);
    endtask

    // four distinct ids in lo..hi
    function automatic t_split distinct_ids(int lo, int hi);
        t_split q;
        do begin
            q.a = t_id'($urandom_range(hi, lo));
            q.b = t_id'($urandom_range(hi, lo));
            q.c = t_id'($urandom_range(hi, lo));
            q.d = t_id'($urandom_range(hi, lo));
        end while (q.a == q.b || q.a == q.c || q.a == q.d ||
                   q.b == q.c || q.b == q.d || q.c == q.d);
        return q;
    endfunction

    // mostly well-formed splits, some tiny ids, some broken ones, some raw noise
    function automatic t_split random_split();
        t_split q;
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
            q = t_split'($urandom);
        end else if (pick == 1) begin
            q = distinct_ids(1, ID_MAX);
            case ($urandom_range(5, 0))
                0: q.a = '0;
                1: q.d = '0;
                2: q.b = q.a;
                3: q.c = q.b;
                4: q.d = q.a;
                default: q.c = q.d;
            endcase
        end else if (pick <= 3) begin
            q = distinct_ids(1, 8);
        end else begin
            q = distinct_ids(1, ID_MAX);
        end
        return q;
    endfunction

    // put one request on the input and hold it until taken
    task automatic offer(t_request rq);
        if (!calm_phase && $urandom_range(3, 0) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        queued_splits.insert(queued_splits.size(), rq);
        i_valid    <= 1'b1;
        i_first_a  <= rq.ids.a;
        i_first_b  <= rq.ids.b;
        i_second_c <= rq.ids.c;
        i_second_d <= rq.ids.d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // result-side backpressure in bursts, none in the calm tail
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm_phase && $urandom_range(2, 0) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(30, 1)) @(posedge i_clk);
            end
        end
    end

    // request and result handshakes, sampled at the edge before new drives land
    always @(posedge i_clk) begin : scoreboard
        t_request rq;
        t_outcome want;
        t_outcome got;
        if (i_rst_n) begin
            // accepted request: queue its expected result first
            if (i_valid && o_ready) begin
                rq = queued_splits.pop_front();
                pending_results.insert(pending_results.size(),
                                       rq.typed ? rq.want : resolve_split(rq.ids));
            end
            // delivered result: compare against the oldest expectation
            if (o_valid && i_ready) begin
                got = '{rank: o_subset_rank, res: o_resolution, bad: o_invalid};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: rank %0d res %0d invalid %0b",
                                 $realtime, got.rank, got.res, got.bad);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected rank %0d res %0d invalid %0b",
                                     $realtime, want.rank, want.res, want.bad,
                                     ", got rank %0d res %0d invalid %0b",
                                     got.rank, got.res, got.bad);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake of either kind
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        // invalid splits: zero ids, every repeated pair, all ids equal
        add_row(0, 1, 2, 3, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(1, 0, 2, 3, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(1, 2, 0, 3, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(1, 2, 3, 0, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(0, 0, 0, 0, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(5, 5, 6, 7, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(5, 6, 5, 7, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(5, 6, 7, 5, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(5, 6, 6, 7, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(5, 6, 7, 6, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(5, 6, 7, 7, 1'b1, 0, RES_AB_CD, 1'b1);
        add_row(255, 255, 255, 255, 1'b1, 0, RES_AB_CD, 1'b1);
        // smallest set in all three resolutions, plus fully reversed input
        add_row(1, 2, 3, 4, 1'b1, 0, RES_AB_CD, 1'b0);
        add_row(1, 3, 2, 4, 1'b1, 0, RES_AC_BD, 1'b0);
        add_row(1, 4, 2, 3, 1'b1, 0, RES_AD_BC, 1'b0);
        add_row(4, 3, 2, 1, 1'b1, 0, RES_AB_CD, 1'b0);
        // largest set gives the top rank
        add_row(252, 253, 254, 255, 1'b1, 172061504, RES_AB_CD, 1'b0);
        // the rest go through the predictor
        add_row(255, 254, 253, 252, 1'b0, 0, RES_AB_CD, 1'b0);
        add_row(255, 1, 128, 2, 1'b0, 0, RES_AB_CD, 1'b0);
        add_row(1, 255, 2, 254, 1'b0, 0, RES_AB_CD, 1'b0);
        add_row(128, 64, 32, 16, 1'b0, 0, RES_AB_CD, 1'b0);
        add_row(2, 3, 1, 4, 1'b0, 0, RES_AB_CD, 1'b0);
        add_row(170, 85, 204, 51, 1'b0, 0, RES_AB_CD, 1'b0);

        // hold synchronous reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) offer(directed_rows[i]);

        // drain the pipeline completely before the random part
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            t_request rq;
            rq.ids   = random_split();
            rq.typed = 1'b0;
            rq.want  = '0;
            if (n == N_RANDOM - N_CALM_TAIL) calm_phase = 1'b1;
            offer(rq);
        end

        // all requests taken: wait out the results, then keep watching for strays
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NSTAGE * 4) @(posedge i_clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
